FILE: rtl/core/marker_steering_decision_macros.svh
// assertion helpers shared by the steering rtl
// both expect clk and rst_n in the enclosing scope
`ifndef MARKER_STEERING_DECISION_MACROS_SVH
`define MARKER_STEERING_DECISION_MACROS_SVH

// same-cycle implication
`define MSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/msd_pkg.sv
`default_nettype none

package msd_pkg;

    // defaults for the top-level parameters
    localparam int COORD_BITS_DEF   = 10;
    localparam int CORDIC_STEPS_DEF = 20;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_DIST   = 2'd1;

    localparam int LIMIT_W = 15;
    localparam int NEAR_W  = 10;
    localparam int ANGLE_W = 16;

    localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST = 15'd2000;
    localparam logic [NEAR_W-1:0]  NEAR_DIST_RST   = 10'd10;

    // action codes
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_FORWARD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LEFT    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RIGHT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAN   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_IDLE    = 3'd4;

    // cordic datapath: prescaled operands always fit 64 bits
    localparam int DW         = 64;
    localparam int ZW         = 34;
    localparam int ANGLE_FRAC = 16;
    localparam int RW         = ZW - ANGLE_FRAC;

    localparam logic signed [ANGLE_W-1:0] ANGLE_90  = 16'sd9000;
    localparam logic signed [ANGLE_W-1:0] ANGLE_180 = 16'sd18000;
    localparam logic signed [RW-1:0]      CLAMP_POS = 18'sd18000;
    localparam logic signed [RW-1:0]      CLAMP_NEG = -18'sd18000;
    localparam logic signed [ZW-1:0]      Z_180     = 34'sd1179648000;
    localparam logic [ZW-1:0]             Z_HALF    = 34'd32768;

    // atan(2^-i) in centidegrees scaled by 2^16
    localparam logic [31:0] ATAN_TAB [0:12] = '{
        32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507,
        32'd23437865,  32'd11730358,  32'd5866610,  32'd2933484,
        32'd1466764,   32'd733385,    32'd366693,   32'd183346,
        32'd91673
    };
    // centidegrees per radian scaled by 2^16, small-angle tail
    localparam logic [63:0] RAD_SCALED = 64'd375493621;

    function automatic logic [31:0] atan_step(input logic [5:0] i);
        logic [63:0] t;
        t = (RAD_SCALED + (64'd1 << (i - 6'd1))) >> i;
        if (i < 6'd13)
        begin
            return ATAN_TAB[i[3:0]];
        end
        return t[31:0];
    endfunction

    // arithmetic shift right that truncates toward zero
    function automatic logic signed [DW-1:0] shr_tz(input logic signed [DW-1:0] v,
                                                    input logic [5:0] s);
        logic [DW-1:0] mag;
        logic [DW-1:0] sh;
        mag = v[DW-1] ? DW'(-v) : DW'(v);
        sh  = mag >> s;
        return v[DW-1] ? -$signed(sh) : $signed(sh);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/marker_steering_decision.sv
// results: the heading is computed through the multiply sequence, cordic rotation and
//   rounding; when markers are missing or a fixed angle applies, rotation and rounding are skipped
// no new item is taken until the previous result is issued, owing to the seven-product multiply
//   sequence and the serial cordic rotator that handles one step per cycle
// reset: engine stopped, held angle 0, angle_limit 2000, near_distance 10
`default_nettype none

`include "marker_steering_decision_macros.svh"

module marker_steering_decision #(
    parameter int COORD_BITS   = msd_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = msd_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [msd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [msd_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [COORD_BITS-1:0]              front_x,
    input  wire logic [COORD_BITS-1:0]              front_y,
    input  wire logic [COORD_BITS-1:0]              rear_x,
    input  wire logic [COORD_BITS-1:0]              rear_y,
    input  wire logic signed [COORD_BITS:0]         goal_x,
    input  wire logic signed [COORD_BITS:0]         goal_y,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [msd_pkg::ACT_W-1:0]               action,
    output logic                                    drive_active,
    output logic                                    engine_on,
    output logic signed [msd_pkg::ANGLE_W-1:0]      heading_angle,
    output logic [COORD_BITS-1:0]                   robot_x,
    output logic [COORD_BITS-1:0]                   robot_y
);

    localparam int C        = COORD_BITS;
    localparam int MW       = C + 3;
    localparam int AW       = 2 * MW;
    localparam int SW       = $clog2(CORDIC_STEPS);
    localparam int PRESCALE = 58 - 2 * C;
    localparam int DW       = msd_pkg::DW;
    localparam int ZW       = msd_pkg::ZW;
    localparam int RW       = msd_pkg::RW;

    localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

    // multiply sequence
    localparam logic [2:0] MS_CROSS_A = 3'd0;
    localparam logic [2:0] MS_CROSS_B = 3'd1;
    localparam logic [2:0] MS_DOT_A   = 3'd2;
    localparam logic [2:0] MS_DOT_B   = 3'd3;
    localparam logic [2:0] MS_DIST_X  = 3'd4;
    localparam logic [2:0] MS_DIST_Y  = 3'd5;
    localparam logic [2:0] MS_NEAR    = 3'd6;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL    = 6'b000010,
        S_PREP   = 6'b000100,
        S_ROT    = 6'b001000,
        S_ROUND  = 6'b010000,
        S_DECIDE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0]    mstep_reg, mstep_next;
    logic [SW-1:0] step_reg, step_next;

    logic [msd_pkg::LIMIT_W-1:0] angle_limit_reg;
    logic [msd_pkg::NEAR_W-1:0]  near_reg;
    logic                        engine_reg, engine_next;
    logic signed [msd_pkg::ANGLE_W-1:0] held_angle_reg, held_angle_next;
    logic                        out_valid_reg, out_valid_next;

    // operands captured at the input transfer
    logic signed [C:0]   dx1_reg, dy1_reg;
    logic signed [C+2:0] dx2_reg, dy2_reg;
    logic signed [C+1:0] dxg_reg, dyg_reg;
    logic [C-1:0]        rx_reg, ry_reg;
    logic                ok_reg, level_reg, vert_reg, target_reg;

    logic signed [AW-1:0] cross_reg, dot_reg, d2_reg, n2_reg;
    logic signed [DW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    logic [msd_pkg::ACT_W-1:0]          act_out_reg;
    logic                               drive_out_reg, eng_out_reg;
    logic signed [msd_pkg::ANGLE_W-1:0] angle_out_reg;
    logic [C-1:0]                       rx_out_reg, ry_out_reg;

    // input transfer arithmetic
    logic          in_xfer;
    logic          a_ok;
    logic [C:0]    a_sum_x, a_sum_y;
    logic [C-1:0]  a_rx, a_ry;

    always_comb
    begin
        in_xfer = in_valid && in_ready;
        a_ok    = (front_x != '0) && (front_y != '0) && (rear_x != '0) && (rear_y != '0);
        a_sum_x = {1'b0, front_x} + {1'b0, rear_x};
        a_sum_y = {1'b0, front_y} + {1'b0, rear_y};
        a_rx    = a_ok ? a_sum_x[C:1] : '0;
        a_ry    = a_ok ? a_sum_y[C:1] : '0;
    end

    // shared multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [AW-1:0] prod;

    always_comb
    begin
        case (mstep_reg)
            MS_CROSS_A:
            begin
                mul_a = MW'(dx1_reg);
                mul_b = MW'(dy2_reg);
            end
            MS_CROSS_B:
            begin
                mul_a = MW'(dx2_reg);
                mul_b = MW'(dy1_reg);
            end
            MS_DOT_A:
            begin
                mul_a = MW'(dx1_reg);
                mul_b = MW'(dx2_reg);
            end
            MS_DOT_B:
            begin
                mul_a = MW'(dy1_reg);
                mul_b = MW'(dy2_reg);
            end
            MS_DIST_X:
            begin
                mul_a = MW'(dxg_reg);
                mul_b = MW'(dxg_reg);
            end
            MS_DIST_Y:
            begin
                mul_a = MW'(dyg_reg);
                mul_b = MW'(dyg_reg);
            end
            MS_NEAR:
            begin
                mul_a = MW'($signed({1'b0, near_reg}));
                mul_b = MW'($signed({1'b0, near_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // cordic set-up and rotation step
    logic signed [DW-1:0] x_pre, y_pre, xs, ys;
    logic signed [ZW-1:0] atan_z;
    logic                 y_pos;

    always_comb
    begin
        x_pre  = DW'(dot_reg) <<< PRESCALE;
        y_pre  = DW'(cross_reg) <<< PRESCALE;
        xs     = msd_pkg::shr_tz(x_reg, 6'(step_reg));
        ys     = msd_pkg::shr_tz(y_reg, 6'(step_reg));
        atan_z = $signed(ZW'(msd_pkg::atan_step(6'(step_reg))));
        y_pos  = !y_reg[DW-1] && (y_reg != '0);
    end

    // negate, round half away from zero, clamp
    logic signed [ZW-1:0] v_neg;
    logic [ZW-1:0]        v_abs, v_q;
    logic signed [RW-1:0] r_val;
    logic signed [msd_pkg::ANGLE_W-1:0] r_clamp;

    always_comb
    begin
        v_neg = -z_reg;
        v_abs = v_neg[ZW-1] ? ZW'(-v_neg) : ZW'(v_neg);
        v_q   = (v_abs + msd_pkg::Z_HALF) >> msd_pkg::ANGLE_FRAC;
        r_val = v_neg[ZW-1] ? -$signed(v_q[RW-1:0]) : $signed(v_q[RW-1:0]);
        if (r_val > msd_pkg::CLAMP_POS)
        begin
            r_clamp = msd_pkg::ANGLE_180;
        end
        else if (r_val < msd_pkg::CLAMP_NEG)
        begin
            r_clamp = -msd_pkg::ANGLE_180;
        end
        else
        begin
            r_clamp = msd_pkg::ANGLE_W'(r_val);
        end
    end

    // action choice from the held angle and the flag before its update
    logic signed [msd_pkg::ANGLE_W:0] h_ext;
    logic [msd_pkg::ANGLE_W:0]        h_abs;
    logic [msd_pkg::ACT_W-1:0]        act_sel;
    logic                             centre_nz;
    logic                             out_free;

    always_comb
    begin
        h_ext = (msd_pkg::ANGLE_W + 1)'(held_angle_reg);
        h_abs = h_ext[msd_pkg::ANGLE_W] ? (msd_pkg::ANGLE_W + 1)'(-h_ext)
                                        : (msd_pkg::ANGLE_W + 1)'(h_ext);
        if (!target_reg || !engine_reg)
        begin
            act_sel = msd_pkg::ACT_IDLE;
        end
        else if (h_abs > (msd_pkg::ANGLE_W + 1)'(angle_limit_reg))
        begin
            act_sel = (held_angle_reg > 0) ? msd_pkg::ACT_RIGHT : msd_pkg::ACT_LEFT;
        end
        else
        begin
            act_sel = (d2_reg > n2_reg) ? msd_pkg::ACT_FORWARD : msd_pkg::ACT_CLEAN;
        end
        centre_nz = (rx_reg != '0) && (ry_reg != '0);
        out_free  = !out_valid_reg || out_ready;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        mstep_next      = mstep_reg;
        step_next       = step_reg;
        held_angle_next = held_angle_reg;
        engine_next     = engine_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    mstep_next = MS_CROSS_A;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mstep_next = mstep_reg + 3'd1;
                if (mstep_reg == MS_NEAR)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                step_next = '0;
                if (!ok_reg)
                begin
                    state_next = S_DECIDE;
                end
                else if (level_reg)
                begin
                    held_angle_next = msd_pkg::ANGLE_90;
                    state_next      = S_DECIDE;
                end
                else if (vert_reg)
                begin
                    held_angle_next = msd_pkg::ANGLE_180;
                    state_next      = S_DECIDE;
                end
                else if ((cross_reg == '0) && (dot_reg == '0))
                begin
                    held_angle_next = '0;
                    state_next      = S_DECIDE;
                end
                else
                begin
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                step_next = step_reg + SW'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                held_angle_next = r_clamp;
                state_next      = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    engine_next    = centre_nz;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mstep_reg       <= '0;
            step_reg        <= '0;
            held_angle_reg  <= '0;
            engine_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            angle_limit_reg <= msd_pkg::ANGLE_LIMIT_RST;
            near_reg        <= msd_pkg::NEAR_DIST_RST;
        end
        else
        begin
            state_reg      <= state_next;
            mstep_reg      <= mstep_next;
            step_reg       <= step_next;
            held_angle_reg <= held_angle_next;
            engine_reg     <= engine_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    msd_pkg::REG_ANGLE_LIMIT:
                    begin
                        angle_limit_reg <= cfg_data[msd_pkg::LIMIT_W-1:0];
                    end
                    msd_pkg::REG_NEAR_DIST:
                    begin
                        near_reg <= cfg_data[msd_pkg::NEAR_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ok_reg     <= a_ok;
            level_reg  <= (front_y == rear_y);
            vert_reg   <= (front_x == rear_x) && (rear_y < front_y);
            target_reg <= !goal_x[C] && !goal_y[C];
            rx_reg     <= a_rx;
            ry_reg     <= a_ry;
            dx1_reg    <= $signed({1'b0, front_x}) - $signed({1'b0, rear_x});
            dy1_reg    <= $signed({1'b0, front_y}) - $signed({1'b0, rear_y});
            dx2_reg    <= (C + 3)'($signed({goal_x, 1'b0})) - $signed({2'b0, a_sum_x});
            dy2_reg    <= (C + 3)'($signed({goal_y, 1'b0})) - $signed({2'b0, a_sum_y});
            dxg_reg    <= (C + 2)'(goal_x) - $signed({2'b0, a_rx});
            dyg_reg    <= (C + 2)'(goal_y) - $signed({2'b0, a_ry});
        end

        if (state_reg == S_MUL)
        begin
            case (mstep_reg)
                MS_CROSS_A: cross_reg <= prod;
                MS_CROSS_B: cross_reg <= cross_reg - prod;
                MS_DOT_A:   dot_reg   <= prod;
                MS_DOT_B:   dot_reg   <= dot_reg + prod;
                MS_DIST_X:  d2_reg    <= prod;
                MS_DIST_Y:  d2_reg    <= d2_reg + prod;
                MS_NEAR:    n2_reg    <= prod;
                default:
                begin
                end
            endcase
        end

        if (state_reg == S_PREP)
        begin
            // rotate into the right half-plane first
            if (dot_reg < 0)
            begin
                x_reg <= -x_pre;
                y_reg <= -y_pre;
                z_reg <= (cross_reg >= 0) ? msd_pkg::Z_180 : -msd_pkg::Z_180;
            end
            else
            begin
                x_reg <= x_pre;
                y_reg <= y_pre;
                z_reg <= '0;
            end
        end
        else if (state_reg == S_ROT)
        begin
            if (y_pos)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_z;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_z;
            end
        end

        if ((state_reg == S_DECIDE) && out_free)
        begin
            act_out_reg   <= act_sel;
            drive_out_reg <= centre_nz && (act_sel != msd_pkg::ACT_IDLE);
            eng_out_reg   <= centre_nz;
            angle_out_reg <= held_angle_reg;
            rx_out_reg    <= rx_reg;
            ry_out_reg    <= ry_reg;
        end
    end

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign action        = act_out_reg;
    assign drive_active  = drive_out_reg;
    assign engine_on     = eng_out_reg;
    assign heading_angle = angle_out_reg;
    assign robot_x       = rx_out_reg;
    assign robot_y       = ry_out_reg;

    `MSD_ASSERT_NXT(a_busy_after_xfer, in_valid && in_ready, !in_ready, "input taken while busy")
    `MSD_ASSERT_IMP(a_angle_range, out_valid, heading_angle >= -16'sd18000 && heading_angle <= 16'sd18000, "heading out of range")
    `MSD_ASSERT_IMP(a_drive_needs_engine, out_valid && drive_active, engine_on && action != msd_pkg::ACT_IDLE, "drive without engine or action")
    `MSD_ASSERT_NXT(a_held_stable_idle, state_reg == S_IDLE, $stable(held_angle_reg), "held angle moved while idle")

endmodule

`default_nettype wire
